// File: sv/spq_pkg.sv
// Shared types, status codes and key helper for the sorted priority queue.
`default_nettype none
package spq_pkg;

	localparam logic [16:0] TIME_SPAN = 17'd100000;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	localparam logic [1:0] CLS_LOWEST = 2'd3;

	typedef struct packed {
		logic [15:0] id;
		logic [1:0]  cls;
		logic [16:0] tim;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic start_ins;
		logic start_pop;
		logic set_full;
		logic set_empty;
		logic shift;
		logic place;
		logic pop_take;
		logic load_out;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic empty;
		logic greater;
		logic last;
		logic out_free;
	} sts_t;

	function automatic logic [18:0] key_of(input logic [1:0] cls, input logic [16:0] tim);
		logic [18:0] base;
		unique case (cls)
			2'd1: base = 19'd100000;
			2'd2: base = 19'd200000;
			2'd3: base = 19'd300000;
			default: base = 19'd0;
		endcase
		return base + 19'(tim);
	endfunction

endpackage
`default_nettype wire

// File: sv/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: controller, datapath and checks.
//
// Sorted priority queue. Each input beat either inserts an entry (op 0) or
// pops the head (op 1); every beat gives exactly one result beat. Inserts
// get a 16-bit sequential id (first id 1) and the key class*100000+time; an
// entry goes behind all held entries of equal or smaller key, so ties leave
// in arrival order. Class 0 counts as class 3 and a time of 100000 or more
// is reduced by 100000. Entries live in a single-port-read, single-port-
// write RAM used as a ring: a pop just moves the head pointer, while an
// insert walks from the tail towards the head, moving one larger-keyed
// entry up per cycle through the RAM's read and write ports. Steps from
// accepted beat to result valid: a pop reads the head in S_POP_RD, a
// full-insert or an empty-pop goes straight to S_FIN, and an insert moves
// one entry per S_INS_CMP step, places itself in S_INS_CMP or S_INS_LAST
// and then reaches S_FIN; the RAM read-modify-write walk sets its length.
// A result left uncollected in the output register holds the sequencer in
// its last state until it goes. One item is worked at a time; in_ready is
// high whenever the sequencer is idle, and a finished result sits in the
// output register so the next beat may be taken before it is collected.
// The RAM needs no clearing after reset: only data from slots below the
// fill count is ever used.
`default_nettype none
module sorted_priority_queue_core #(
	parameter int QUEUE_DEPTH = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [1:0]  priority_class,
	input  wire logic [16:0] arrival_time,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [15:0]      entry_id,
	output logic [1:0]       entry_class,
	output logic [16:0]      entry_time,
	output logic [18:0]      order_key,
	output logic [7:0]       occupancy
);
	import spq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: decides full/empty, runs the insertion walk
	spq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.op      (op),
		.sts     (sts),
		.in_ready(in_ready),
		.cmd     (cmd)
	);

	// storage, counters, result and output register
	spq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.priority_class(priority_class),
		.arrival_time  (arrival_time),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.entry_id      (entry_id),
		.entry_class   (entry_class),
		.entry_time    (entry_time),
		.order_key     (order_key),
		.occupancy     (occupancy)
	);

`ifndef SYNTHESIS
	// one item at a time: the sequencer is busy right after taking a beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an accepted beat");

	// a queue cannot be both full and empty
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.full && sts.empty))
		else $error("fill count reports full and empty together");

	// a rejected item carries no entry
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_EMPTY) |->
		entry_id == 16'd0 && entry_class == 2'd0 && order_key == 19'd0)
		else $error("rejected result carries entry data");

	// a completed item always names a real class
	a_done_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DONE |-> entry_class != 2'd0)
		else $error("completed result with class zero");
`endif

endmodule
`default_nettype wire

// File: sv/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spq_ram #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: sv/spq_ctrl.sv
// Sequencer for insert (insertion shift) and pop operations.
`default_nettype none
module spq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          op,
	input  wire spq_pkg::sts_t sts,
	output logic               in_ready,
	output spq_pkg::cmd_t      cmd
);
	import spq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_RD,
		S_INS_CMP,
		S_INS_LAST,
		S_FIN
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op == OP_INSERT) begin
						if (sts.full) begin
							cmd.set_full = 1'b1;
							state_d      = S_FIN;
						end else begin
							cmd.start_ins = 1'b1;
							state_d       = sts.empty ? S_INS_LAST : S_INS_CMP;
						end
					end else begin
						if (sts.empty) begin
							cmd.set_empty = 1'b1;
							state_d       = S_FIN;
						end else begin
							cmd.start_pop = 1'b1;
							state_d       = S_POP_RD;
						end
					end
				end
			end
			S_POP_RD: begin
				cmd.pop_take = 1'b1;
				state_d      = S_FIN;
			end
			S_INS_CMP: begin
				if (sts.greater) begin
					cmd.shift = 1'b1;
					if (sts.last) begin
						state_d = S_INS_LAST;
					end
				end else begin
					cmd.place = 1'b1;
					state_d   = S_FIN;
				end
			end
			S_INS_LAST: begin
				cmd.place = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/spq_dp.sv
// Datapath: circular sorted store, counters, result and output registers.
`default_nettype none
module spq_dp #(
	parameter int QUEUE_DEPTH = 128
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire spq_pkg::cmd_t cmd,
	output spq_pkg::sts_t      sts,
	input  wire logic [1:0]    priority_class,
	input  wire logic [16:0]   arrival_time,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [1:0]         status,
	output logic [15:0]        entry_id,
	output logic [1:0]         entry_class,
	output logic [16:0]        entry_time,
	output logic [18:0]        order_key,
	output logic [7:0]         occupancy
);
	import spq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);

	logic [CW-1:0] count_q;
	logic [15:0]   next_id_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] pos_q;
	entry_t        fresh_q;
	logic [18:0]   fresh_key_q;

	logic [1:0]  res_status_q;
	entry_t      res_entry_q;
	logic [18:0] res_key_q;
	logic        out_valid_q;

	entry_t      rd_entry;
	logic [AW-1:0] rd_l;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic          we;
	entry_t        wdata;
	entry_t        in_entry;
	logic [1:0]    in_cls;
	logic [16:0]   in_tim;

	// logical slot -> physical address, ring starting at head
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [AW-1:0] l);
		logic [AW:0] s;
		s = {1'b0, head} + {1'b0, l};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	always_comb begin
		in_cls = (priority_class == 2'd0) ? CLS_LOWEST : priority_class;
		in_tim = (arrival_time >= TIME_SPAN) ? arrival_time - TIME_SPAN : arrival_time;
		in_entry.id  = next_id_q;
		in_entry.cls = in_cls;
		in_entry.tim = in_tim;
	end

	always_comb begin
		if (cmd.start_pop) begin
			rd_l = '0;
		end else if (cmd.start_ins) begin
			rd_l = count_q[AW-1:0] - AW'(1);
		end else begin
			rd_l = pos_q - AW'(2);
		end
		raddr = phys(head_q, rd_l);
		waddr = phys(head_q, pos_q);
		we    = cmd.shift | cmd.place;
		wdata = cmd.shift ? rd_entry : fresh_q;
	end

	spq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_entry)
	);

	always_comb begin
		sts.full     = (count_q == CW'(QUEUE_DEPTH));
		sts.empty    = (count_q == '0);
		sts.greater  = key_of(rd_entry.cls, rd_entry.tim) > fresh_key_q;
		sts.last     = (pos_q == AW'(1));
		sts.out_free = !out_valid_q || out_ready;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			next_id_q   <= 16'd1;
			head_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start_ins) begin
				next_id_q <= next_id_q + 16'd1;
			end
			if (cmd.place) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.pop_take) begin
				count_q <= count_q - CW'(1);
				head_q  <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.start_ins) begin
			fresh_q      <= in_entry;
			fresh_key_q  <= key_of(in_cls, in_tim);
			pos_q        <= count_q[AW-1:0];
			res_status_q <= ST_DONE;
			res_entry_q  <= in_entry;
			res_key_q    <= key_of(in_cls, in_tim);
		end
		if (cmd.shift) begin
			pos_q <= pos_q - AW'(1);
		end
		if (cmd.set_full || cmd.set_empty) begin
			res_status_q <= cmd.set_full ? ST_FULL : ST_EMPTY;
			res_entry_q  <= '0;
			res_key_q    <= '0;
		end
		if (cmd.pop_take) begin
			res_status_q <= ST_DONE;
			res_entry_q  <= rd_entry;
			res_key_q    <= key_of(rd_entry.cls, rd_entry.tim);
		end
		if (cmd.load_out) begin
			status      <= res_status_q;
			entry_id    <= res_entry_q.id;
			entry_class <= res_entry_q.cls;
			entry_time  <= res_entry_q.tim;
			order_key   <= res_key_q;
			occupancy   <= 8'(count_q);
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: tb/sorted_priority_queue_core_test.sv
// Self-checking testbench for the sorted priority queue core.
`default_nettype none
module sorted_priority_queue_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int QUEUE_DEPTH = 128;
	// Quiet cycles tolerated before the run is declared hung. The slowest legal
	// gap is the receiver hold-off (HOLD_CYCLES) on top of a full-depth insert
	// walk and a capped sender gap, so this leaves a wide margin.
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 600;
	localparam int NUM_DIRECTED = 23;
	localparam int RANDOM_PER_MODE = 190;

	// One result beat, field for field as the ports present it.
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] id;
		logic [1:0]  cls;
		logic [16:0] tim;
		logic [18:0] key;
		logic [7:0]  occ;
	} beat_result_t;

	// One stimulus row; typed rows carry a hand-written expected result.
	typedef struct packed {
		logic         op;
		logic [1:0]   cls;
		logic [16:0]  tim;
		logic         typed;
		beat_result_t res;
	} stim_row_t;

	localparam beat_result_t UNTYPED = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        op = 1'b0;
	logic [1:0]  priority_class = 2'd0;
	logic [16:0] arrival_time = 17'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [15:0] entry_id;
	logic [1:0]  entry_class;
	logic [16:0] entry_time;
	logic [18:0] order_key;
	logic [7:0]  occupancy;

	// Shadow copy of the queue contents, kept sorted by key, plus the id counter.
	entry_t       held_entries[$];
	logic [15:0]  id_next;
	// Results still owed by the block, oldest first.
	beat_result_t owed_results[$];

	stim_row_t directed_rows [NUM_DIRECTED];

	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	int quiet_cycles = 0;
	int err_count = 0;
	int beats_sent = 0;
	int results_checked = 0;
	int full_drops = 0;
	int empty_pops = 0;
	int peak_fill = 0;
	int id_wraps = 0;

	sorted_priority_queue_core #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.priority_class(priority_class),
		.arrival_time(arrival_time),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_id(entry_id),
		.entry_class(entry_class),
		.entry_time(entry_time),
		.order_key(order_key),
		.occupancy(occupancy)
	);

	always #1 clk = ~clk;

	function automatic logic [18:0] sort_key(input entry_t e);
		return 19'(e.cls) * 19'(TIME_SPAN) + 19'(e.tim);
	endfunction

	// Advance the shadow queue by one accepted beat and return the result the
	// block owes for it.
	function automatic beat_result_t predict_beat(input logic op_bit, input logic [1:0] c,
			input logic [16:0] t);
		beat_result_t r;
		entry_t e;
		int pos;
		r = '0;
		if (op_bit == OP_INSERT) begin
			if (held_entries.size() >= QUEUE_DEPTH) begin
				// full: dropped, id counter untouched
				r.status = ST_FULL;
				full_drops++;
			end else begin
				e.id = id_next;
				e.cls = (c == 2'd0) ? CLS_LOWEST : c;
				e.tim = (t >= TIME_SPAN) ? t - TIME_SPAN : t;
				id_next = id_next + 16'd1;
				if (id_next == 16'd0)
					id_wraps++;
				// behind every entry of equal or smaller key
				pos = held_entries.size();
				while (pos > 0 && sort_key(held_entries[pos - 1]) > sort_key(e))
					pos--;
				held_entries.insert(pos, e);
				if (held_entries.size() > peak_fill)
					peak_fill = held_entries.size();
				r.status = ST_DONE;
				r.id = e.id;
				r.cls = e.cls;
				r.tim = e.tim;
				r.key = sort_key(e);
			end
		end else begin
			if (held_entries.size() == 0) begin
				r.status = ST_EMPTY;
				empty_pops++;
			end else begin
				e = held_entries.pop_front();
				r.status = ST_DONE;
				r.id = e.id;
				r.cls = e.cls;
				r.tim = e.tim;
				r.key = sort_key(e);
			end
		end
		r.occ = 8'(held_entries.size());
		return r;
	endfunction

	// Random beat. Times lean towards the legal range, with some out of range,
	// some at the ends and some tiny ones so that equal keys turn up often.
	function automatic stim_row_t random_row(input int insert_pct);
		stim_row_t row;
		row = '0;
		row.op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_POP;
		row.cls = 2'($urandom_range(3));
		case ($urandom_range(9))
			7: row.tim = $urandom_range(1) ? 17'd99999 : 17'd0;
			8: row.tim = 17'($urandom_range(3));
			9: row.tim = 17'($urandom_range(131071));
			default: row.tim = 17'($urandom_range(99999));
		endcase
		return row;
	endfunction

	// Offer one beat, holding it until the block takes it, then book the
	// expected result. valid is only lowered when a gap is drawn, so it is
	// never dropped and raised within one step.
	task automatic send_beat(input stim_row_t row);
		int gap;
		beat_result_t predicted;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= row.op;
		priority_class <= row.cls;
		arrival_time <= row.tim;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = predict_beat(row.op, row.cls, row.tim);
		owed_results.push_back(row.typed ? row.res : predicted);
		beats_sent++;
	endtask

	// Sender goes quiet until every owed result has been collected.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: random back-pressure, plus a long hold-off on request so the
	// output register and the sequencer both fill and in_ready drops.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result checker: every accepted result beat against the oldest owed one.
	always @(posedge clk) begin
		beat_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				$error("result beat with nothing owed: status %0d id %0d", status, entry_id);
				err_count++;
			end else begin
				want = owed_results.pop_front();
				results_checked++;
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					err_count++;
				end
				if (entry_id !== want.id) begin
					$error("entry_id: expected %0d, got %0d", want.id, entry_id);
					err_count++;
				end
				if (entry_class !== want.cls) begin
					$error("entry_class: expected %0d, got %0d", want.cls, entry_class);
					err_count++;
				end
				if (entry_time !== want.tim) begin
					$error("entry_time: expected %0d, got %0d", want.tim, entry_time);
					err_count++;
				end
				if (order_key !== want.key) begin
					$error("order_key: expected %0d, got %0d", want.key, order_key);
					err_count++;
				end
				if (occupancy !== want.occ) begin
					$error("occupancy: expected %0d, got %0d", want.occ, occupancy);
					err_count++;
				end
			end
		end
	end

	// Watchdog: any beat on either channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("[sorted_priority_queue_core] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int mix_pct [4];
		stim_row_t row;

		held_entries.delete();
		owed_results.delete();
		id_next = 16'd1;
		mix_pct = '{80, 60, 30, 50};

		// Directed beats. Typed rows are read straight off the spec: empty
		// pops, the first inserts after reset (ids from 1), class zero mapped
		// to the lowest class, times past the span folded back, key ties.
		directed_rows = '{
			'{OP_POP,    2'd0, 17'd0,      1'b1, '{ST_EMPTY, 16'd0, 2'd0, 17'd0, 19'd0, 8'd0}},
			'{OP_INSERT, 2'd1, 17'd0,      1'b1, '{ST_DONE, 16'd1, 2'd1, 17'd0, 19'd100000, 8'd1}},
			'{OP_INSERT, 2'd3, 17'd99999,  1'b1,
				'{ST_DONE, 16'd2, 2'd3, 17'd99999, 19'd399999, 8'd2}},
			'{OP_INSERT, 2'd0, 17'd5,      1'b1, '{ST_DONE, 16'd3, 2'd3, 17'd5, 19'd300005, 8'd3}},
			'{OP_INSERT, 2'd2, 17'd131071, 1'b1,
				'{ST_DONE, 16'd4, 2'd2, 17'd31071, 19'd231071, 8'd4}},
			'{OP_INSERT, 2'd1, 17'd100000, 1'b1, '{ST_DONE, 16'd5, 2'd1, 17'd0, 19'd100000, 8'd5}},
			'{OP_INSERT, 2'd2, 17'd99999,  1'b1,
				'{ST_DONE, 16'd6, 2'd2, 17'd99999, 19'd299999, 8'd6}},
			'{OP_INSERT, 2'd1, 17'd100001, 1'b1, '{ST_DONE, 16'd7, 2'd1, 17'd1, 19'd100001, 8'd7}},
			'{OP_INSERT, 2'd3, 17'd0,      1'b0, UNTYPED},
			// drain in key order; pops carry junk class/time that must be ignored
			'{OP_POP,    2'd3, 17'd131071, 1'b0, UNTYPED},
			'{OP_POP,    2'd0, 17'd0,      1'b0, UNTYPED},
			'{OP_POP,    2'd2, 17'd65536,  1'b0, UNTYPED},
			'{OP_POP,    2'd1, 17'd1,      1'b0, UNTYPED},
			'{OP_POP,    2'd0, 17'd0,      1'b0, UNTYPED},
			'{OP_POP,    2'd3, 17'd99999,  1'b0, UNTYPED},
			'{OP_POP,    2'd0, 17'd0,      1'b0, UNTYPED},
			'{OP_POP,    2'd0, 17'd0,      1'b0, UNTYPED},
			'{OP_POP,    2'd3, 17'd131071, 1'b1, '{ST_EMPTY, 16'd0, 2'd0, 17'd0, 19'd0, 8'd0}},
			// equal keys must leave in arrival order
			'{OP_INSERT, 2'd2, 17'd65535,  1'b0, UNTYPED},
			'{OP_INSERT, 2'd2, 17'd65535,  1'b0, UNTYPED},
			'{OP_POP,    2'd0, 17'd0,      1'b0, UNTYPED},
			'{OP_POP,    2'd0, 17'd0,      1'b0, UNTYPED},
			'{OP_POP,    2'd0, 17'd0,      1'b1, '{ST_EMPTY, 16'd0, 2'd0, 17'd0, 19'd0, 8'd0}}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i]);
		wait_drained();

		// Random traffic under four handshake regimes: none, sender gaps,
		// receiver stalls, both. The insert bias swings so the fill rises and
		// falls; each regime ends with the sender waiting for a full drain.
		for (int mode = 0; mode < 4; mode++) begin
			case (mode)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 48; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 48; end
				default: begin send_idle_pct = 11; stall_pct = 11; end
			endcase
			for (int n = 0; n < RANDOM_PER_MODE; n++)
				send_beat(random_row(mix_pct[(n / 48) % 4]));
			wait_drained();
		end

		// Fill to the brim with falling keys, so each insert walks past every
		// entry of this fill, while the receiver holds off and the input backs up;
		// the last few inserts find the queue full. Then drain past empty.
		send_idle_pct = 11;
		stall_pct = 11;
		hold_req <= 1'b1;
		for (int i = 0; i < QUEUE_DEPTH + 3; i++) begin
			row = '0;
			row.op = OP_INSERT;
			row.cls = 2'd3;
			row.tim = 17'(99999 - i * 500);
			send_beat(row);
		end
		wait_drained();
		for (int i = 0; i <= QUEUE_DEPTH; i++) begin
			row = random_row(0);
			send_beat(row);
		end
		wait_drained();

		// allow for a late or stray result beat
		repeat (QUEUE_DEPTH + 8) @(posedge clk);

		$display("run: %0d beats in, %0d results checked, %0d full drops, %0d empty pops",
			beats_sent, results_checked, full_drops, empty_pops);
		$display("     peak fill %0d of %0d, id counter wrapped %0d time(s)",
			peak_fill, QUEUE_DEPTH, id_wraps);
		if (err_count == 0 && owed_results.size() == 0) begin
			$display("[sorted_priority_queue_core] OK");
		end else begin
			$display("[sorted_priority_queue_core] ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
